// ===== hdl/dcc_pkg.sv =====
package dcc_pkg;

  // Field widths
  localparam int unsigned OffW   = 23;
  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;

  // Julian day number landmarks
  localparam int JdnEpoch1950  = 2433283;
  localparam int JdnFirstValid = 1721424;
  localparam int JdnLastValid  = 5373484;
  localparam int JdnOct1Of1582 = 2299157;
  localparam int JdnNov1Of1582 = 2299178;
  localparam int JdnMar0Jul    = 1721118;
  localparam int JdnMar0Greg   = 1721120;
  localparam int ChangeBase    = JdnOct1Of1582 - 1;

  localparam int unsigned ChangeYear  = 1582;
  localparam int unsigned ChangeMonth = 10;
  localparam int unsigned GregEraLen  = 146097;
  localparam int unsigned MarchMonths = 10;

  // Constant divider: operand width, reciprocal shift and widths
  localparam int unsigned ZW         = 22;
  localparam int unsigned RecipShift = 22;
  localparam int unsigned MW         = 16;
  localparam int unsigned DW         = 18;
  localparam int unsigned QW         = 16;

  typedef enum logic [2:0] {
    OP_ERA,
    OP_CYC,
    OP_Q1460,
    OP_Q36524,
    OP_YOE,
    OP_C100,
    OP_MP
  } op_e;

  typedef enum logic [1:0] {
    CLS_INVALID,
    CLS_CHANGE,
    CLS_JULIAN,
    CLS_GREG
  } cls_e;

  typedef struct packed {
    logic take_in;
    logic load_x;
    logic mul_en;
    logic back_en;
    logic write_en;
    logic publish;
    op_e  op;
  } cmd_t;

  typedef struct packed {
    cls_e cls;
  } sts_t;

  typedef struct packed {
    logic [DW-1:0] d;
    logic [MW-1:0] m;
  } recip_t;

  // Divisor and floor(2^RecipShift / divisor) for each operation
  function automatic recip_t div_recip(op_e op);
    recip_t r;
    case (op)
      OP_ERA:    r = '{d: DW'(146097), m: MW'(28)};
      OP_CYC:    r = '{d: DW'(1461),   m: MW'(2870)};
      OP_Q1460:  r = '{d: DW'(1460),   m: MW'(2872)};
      OP_Q36524: r = '{d: DW'(36524),  m: MW'(114)};
      OP_YOE:    r = '{d: DW'(365),    m: MW'(11491)};
      OP_C100:   r = '{d: DW'(100),    m: MW'(41943)};
      OP_MP:     r = '{d: DW'(153),    m: MW'(27413)};
      default:   r = '{d: DW'(153),    m: MW'(27413)};
    endcase
    return r;
  endfunction

  // First day of each month in a March-based year
  function automatic logic [8:0] month_start(logic [3:0] mp);
    logic [8:0] s;
    case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

// ===== hdl/dcc_cdiv.sv =====
module dcc_cdiv (
  input  logic                     clk_i,
  input  logic                     load_i,
  input  logic                     mul_en_i,
  input  logic                     back_en_i,
  input  dcc_pkg::op_e             op_i,
  input  logic [dcc_pkg::ZW-1:0]   x_i,
  output logic [dcc_pkg::QW-1:0]   q_o,
  output logic [dcc_pkg::ZW-1:0]   rem_o
);
  import dcc_pkg::*;

  recip_t                rc;
  logic [ZW-1:0]         x_q;
  logic [ZW+MW-1:0]      prod_q;
  logic [QW-1:0]         qe;
  logic [QW-1:0]         qe_q;
  logic [QW+DW-1:0]      qd_full;
  logic [ZW-1:0]         qd_q;
  logic [ZW-1:0]         rem_raw;
  logic [ZW-1:0]         d_ext;
  logic                  fix;

  assign rc      = div_recip(op_i);
  assign d_ext   = ZW'(rc.d);
  // estimate is exact or one short
  assign qe      = prod_q[RecipShift+QW-1:RecipShift];
  assign qd_full = (QW+DW)'(qe) * (QW+DW)'(rc.d);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      x_q <= x_i;
    end
    if (mul_en_i) begin
      prod_q <= (ZW+MW)'(x_q) * (ZW+MW)'(rc.m);
    end
    if (back_en_i) begin
      qe_q <= qe;
      qd_q <= qd_full[ZW-1:0];
    end
  end

  assign rem_raw = x_q - qd_q;
  assign fix     = (rem_raw >= d_ext);
  assign q_o     = fix ? qe_q + QW'(1) : qe_q;
  assign rem_o   = fix ? rem_raw - d_ext : rem_raw;

endmodule

// ===== hdl/dcc_datapath.sv =====
module dcc_datapath (
  input  logic                          clk_i,
  input  dcc_pkg::cmd_t                 cmd_i,
  input  logic [dcc_pkg::OffW-1:0]      day_offset_i,
  output dcc_pkg::sts_t                 sts_o,
  output logic [dcc_pkg::YearW-1:0]     year_o,
  output logic [dcc_pkg::MonthW-1:0]    month_o,
  output logic [dcc_pkg::DayW-1:0]      day_of_month_o,
  output logic                          valid_res_o
);
  import dcc_pkg::*;

  // intake
  logic signed [23:0] jdn;
  logic [23:0]        zj;
  logic [23:0]        zg;
  logic [23:0]        chg_full;
  cls_e               cls_d;

  // working registers
  cls_e               cls_q;
  logic [ZW-1:0]      z_q;
  logic [DayW-1:0]    chg_day_q;
  logic [8:0]         era_q;
  logic [17:0]        doe_q;
  logic [6:0]         qa_q;
  logic [2:0]         qb_q;
  logic [8:0]         yoe_q;
  logic [8:0]         r365_q;
  logic [1:0]         c100_q;
  logic [3:0]         mp_q;
  logic [8:0]         doy_q;

  logic               greg;
  logic               doe_last;
  logic [17:0]        num;
  logic [9:0]         doy_w;
  logic [8:0]         doy_c;
  logic [10:0]        mp_arg;
  logic [ZW-1:0]      operand;
  logic [QW-1:0]      div_q;
  logic [ZW-1:0]      div_rem;

  logic [YearW-1:0]   year_c;
  logic [YearW-1:0]   yr_base;
  logic [MonthW-1:0]  month_c;
  logic [DayW-1:0]    day_c;
  logic [8:0]         day_w;

  assign jdn      = $signed({day_offset_i[OffW-1], day_offset_i}) + 24'(JdnEpoch1950);
  assign zj       = jdn - 24'(JdnMar0Jul);
  assign zg       = jdn - 24'(JdnMar0Greg);
  assign chg_full = jdn - 24'(ChangeBase);

  always_comb begin
    if (jdn < $signed(24'(JdnFirstValid)) || jdn > $signed(24'(JdnLastValid))) begin
      cls_d = CLS_INVALID;
    end else if (jdn >= $signed(24'(JdnNov1Of1582))) begin
      cls_d = CLS_GREG;
    end else if (jdn >= $signed(24'(JdnOct1Of1582))) begin
      cls_d = CLS_CHANGE;
    end else begin
      cls_d = CLS_JULIAN;
    end
  end

  assign greg     = (cls_q == CLS_GREG);
  assign doe_last = (doe_q == 18'(GregEraLen - 1));
  assign num      = doe_q - 18'(qa_q) + 18'(qb_q) - 18'(doe_last);
  // day of March-based year, rebuilt from the remainder of the year division
  assign doy_w    = 10'(r365_q) + 10'(qa_q) - 10'(qb_q) + 10'(doe_last)
                  - (greg ? 10'(yoe_q[8:2]) : 10'd0) + 10'(c100_q);
  assign doy_c    = doy_w[8:0];
  assign mp_arg   = 11'({doy_c, 2'b00}) + 11'(doy_c) + 11'd2;

  always_comb begin
    case (cmd_i.op)
      OP_ERA, OP_CYC:      operand = z_q;
      OP_Q1460, OP_Q36524: operand = ZW'(doe_q);
      OP_YOE:              operand = ZW'(num);
      OP_C100:             operand = ZW'(yoe_q);
      OP_MP:               operand = ZW'(mp_arg);
      default:             operand = z_q;
    endcase
  end

  dcc_cdiv u_cdiv (
    .clk_i     (clk_i),
    .load_i    (cmd_i.load_x),
    .mul_en_i  (cmd_i.mul_en),
    .back_en_i (cmd_i.back_en),
    .op_i      (cmd_i.op),
    .x_i       (operand),
    .q_o       (div_q),
    .rem_o     (div_rem)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_in) begin
      cls_q     <= cls_d;
      z_q       <= (cls_d == CLS_GREG) ? zg[ZW-1:0] : zj[ZW-1:0];
      chg_day_q <= chg_full[DayW-1:0];
      qb_q      <= '0;
      c100_q    <= '0;
    end
    if (cmd_i.load_x && cmd_i.op == OP_MP) begin
      doy_q <= doy_c;
    end
    if (cmd_i.write_en) begin
      case (cmd_i.op)
        OP_ERA, OP_CYC: begin
          era_q <= div_q[8:0];
          doe_q <= div_rem[17:0];
        end
        OP_Q1460:  qa_q <= div_q[6:0];
        OP_Q36524: qb_q <= div_q[2:0];
        OP_YOE: begin
          yoe_q  <= div_q[8:0];
          r365_q <= div_rem[8:0];
        end
        OP_C100:   c100_q <= div_q[1:0];
        OP_MP:     mp_q <= div_q[3:0];
        default:   mp_q <= div_q[3:0];
      endcase
    end
  end

  // final assembly
  assign yr_base = greg ? YearW'(era_q) * YearW'(400) : YearW'({era_q, 2'b00});
  assign year_c  = yr_base + YearW'(yoe_q) + YearW'(mp_q >= 4'(MarchMonths));
  assign month_c = (mp_q < 4'(MarchMonths)) ? mp_q + 4'd3 : mp_q - 4'd9;
  assign day_w   = doy_q - month_start(mp_q) + 9'd1;
  assign day_c   = day_w[DayW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      case (cls_q)
        CLS_INVALID: begin
          year_o         <= '0;
          month_o        <= '0;
          day_of_month_o <= '0;
          valid_res_o    <= 1'b0;
        end
        CLS_CHANGE: begin
          year_o         <= YearW'(ChangeYear);
          month_o        <= MonthW'(ChangeMonth);
          day_of_month_o <= chg_day_q;
          valid_res_o    <= 1'b1;
        end
        default: begin
          year_o         <= year_c;
          month_o        <= month_c;
          day_of_month_o <= day_c;
          valid_res_o    <= 1'b1;
        end
      endcase
    end
  end

  assign sts_o.cls = cls_q;

endmodule

// ===== hdl/dcc_ctrl.sv =====
module dcc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  input  dcc_pkg::sts_t  sts_i,
  output dcc_pkg::cmd_t  cmd_o
);
  import dcc_pkg::*;

  localparam logic [2:0] StIdle     = 3'd0;
  localparam logic [2:0] StDispatch = 3'd1;
  localparam logic [2:0] StLoad     = 3'd2;
  localparam logic [2:0] StMul      = 3'd3;
  localparam logic [2:0] StBack     = 3'd4;
  localparam logic [2:0] StWrite    = 3'd5;
  localparam logic [2:0] StDone     = 3'd6;

  logic [2:0] state_q, state_d;
  op_e        op_q, op_d;
  logic       out_valid_q, out_valid_d;
  logic       greg;

  assign greg = (sts_i.cls == CLS_GREG);

  function automatic op_e next_op(op_e op, logic is_greg);
    op_e n;
    case (op)
      OP_ERA, OP_CYC: n = OP_Q1460;
      OP_Q1460:       n = is_greg ? OP_Q36524 : OP_YOE;
      OP_Q36524:      n = OP_YOE;
      OP_YOE:         n = is_greg ? OP_C100 : OP_MP;
      default:        n = OP_MP;
    endcase
    return n;
  endfunction

  always_comb begin
    state_d       = state_q;
    op_d          = op_q;
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    cmd_o.op      = op_q;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take_in = 1'b1;
          state_d       = StDispatch;
        end
      end
      StDispatch: begin
        case (sts_i.cls)
          CLS_GREG: begin
            op_d    = OP_ERA;
            state_d = StLoad;
          end
          CLS_JULIAN: begin
            op_d    = OP_CYC;
            state_d = StLoad;
          end
          default: state_d = StDone;
        endcase
      end
      StLoad: begin
        cmd_o.load_x = 1'b1;
        state_d      = StMul;
      end
      StMul: begin
        cmd_o.mul_en = 1'b1;
        state_d      = StBack;
      end
      StBack: begin
        cmd_o.back_en = 1'b1;
        state_d       = StWrite;
      end
      StWrite: begin
        cmd_o.write_en = 1'b1;
        if (op_q == OP_MP) begin
          state_d = StDone;
        end else begin
          op_d    = next_op(op_q, greg);
          state_d = StLoad;
        end
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.publish = 1'b1;
          state_d       = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.publish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      op_q        <= OP_ERA;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hdl/day_count_to_calendar_date.sv =====
// Day count to calendar date converter.
// Input channel (in_valid_i / in_ready_o) carries a signed day count since
// 1950-01-01; output channel (out_valid_o / out_ready_i) returns year, month,
// day of month and a valid flag. One result transaction per input transaction.
// Julian calendar before the October 1582 changeover, Gregorian after; that
// October is returned as one month of days 1 to 21. Offsets outside years
// 1 to 9999 give valid_res_o low and zero fields.
// One shared constant divider (reciprocal multiply, back-multiply, correct)
// runs each division through load, multiply, back-multiply and write steps.
// Gregorian dates need 6 divisions, Julian dates 4; the changeover month and
// out-of-range offsets need none. A new transaction is accepted only once
// the previous one has reached the output register.
// A stalled receiver holds the output register; the next item is still taken
// and computed, and waits in its final state until the output register frees.
// Reset clears the controller and the output valid; no stored state otherwise.
module day_count_to_calendar_date (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [dcc_pkg::OffW-1:0]      day_offset_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [dcc_pkg::YearW-1:0]     year_o,
  output logic [dcc_pkg::MonthW-1:0]    month_o,
  output logic [dcc_pkg::DayW-1:0]      day_of_month_o,
  output logic                          valid_res_o
);
  import dcc_pkg::*;

  // controller <-> datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: dispatch on date class, then step through the divisions
  dcc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // classification, shared divider, working registers and output register
  dcc_datapath u_datapath (
    .clk_i          (clk_i),
    .cmd_i          (cmd),
    .day_offset_i   (day_offset_i),
    .sts_o          (sts),
    .year_o         (year_o),
    .month_o        (month_o),
    .day_of_month_o (day_of_month_o),
    .valid_res_o    (valid_res_o)
  );

endmodule

// ===== tb/dcc_checker.sv =====
module dcc_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic [dcc_pkg::OffW-1:0]   day_offset_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic [dcc_pkg::YearW-1:0]  year_i,
  input  logic [dcc_pkg::MonthW-1:0] month_i,
  input  logic [dcc_pkg::DayW-1:0]   day_of_month_i,
  input  logic                       valid_res_i,
  output int unsigned                mismatch_count_o,
  output int unsigned                dates_owed_o
);
  import dcc_pkg::*;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic              ok;
  } date_t;

  date_t       dates_due[$];
  int unsigned mismatches;
  int unsigned owed;

  assign mismatch_count_o = mismatches;
  assign dates_owed_o     = owed;

  // Day count to civil date through the Julian day number; March-based years
  function automatic date_t civil_date(logic signed [OffW-1:0] off);
    date_t  r;
    longint jdn, z, blk, rem, yoe, doy, mp, yr, mon;
    r   = '0;
    jdn = longint'(off) + longint'(JdnEpoch1950);
    if (jdn < JdnFirstValid || jdn > JdnLastValid) begin
      return r;
    end
    r.ok = 1'b1;
    if (jdn >= JdnNov1Of1582) begin
      z   = jdn - JdnMar0Greg;
      blk = z / 146097;
      rem = z - blk * 146097;
      yoe = (rem - rem / 1460 + rem / 36524 - rem / 146096) / 365;
      doy = rem - (365 * yoe + yoe / 4 - yoe / 100);
      yr  = yoe + 400 * blk;
    end else if (jdn >= JdnOct1Of1582) begin
      // changeover October: one run of 21 days
      r.year  = YearW'(ChangeYear);
      r.month = MonthW'(ChangeMonth);
      z       = jdn - JdnOct1Of1582 + 1;
      r.day   = z[DayW-1:0];
      return r;
    end else begin
      z   = jdn - JdnMar0Jul;
      blk = z / 1461;
      rem = z - blk * 1461;
      yoe = (rem - rem / 1460) / 365;
      doy = rem - 365 * yoe;
      yr  = yoe + 4 * blk;
    end
    mp  = (5 * doy + 2) / 153;
    z   = doy - (153 * mp + 2) / 5 + 1;
    mon = (mp < 10) ? mp + 3 : mp - 9;
    if (mon <= 2) begin
      yr = yr + 1;
    end
    r.year  = yr[YearW-1:0];
    r.month = mon[MonthW-1:0];
    r.day   = z[DayW-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    date_t want, seen;
    if (!rst_ni) begin
      dates_due.delete();
      mismatches = 0;
      owed       = 0;
    end else begin
      // a result can never belong to the transaction taken at the same edge
      if (out_valid_i && out_ready_i) begin
        seen = '{year: year_i, month: month_i, day: day_of_month_i, ok: valid_res_i};
        if (dates_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result transaction: expected none, actual %0d-%0d-%0d v%0b",
                   $time, seen.year, seen.month, seen.day, seen.ok);
        end else begin
          want = dates_due.pop_front();
          if (seen !== want) begin
            mismatches++;
            $display("%0t: date mismatch: expected %0d-%0d-%0d v%0b, actual %0d-%0d-%0d v%0b",
                     $time, want.year, want.month, want.day, want.ok,
                     seen.year, seen.month, seen.day, seen.ok);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        dates_due.push_back(civil_date(day_offset_i));
      end
      owed = dates_due.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  import dcc_pkg::*;

  // cycles without any transaction before the run is declared hung
  localparam int unsigned StallLimit   = 3000;
  // long receiver hold-off, enough to fill the block and back up the input
  localparam int unsigned RxHoldCycles = 300;
  // settle time after the last result
  localparam int unsigned DrainCycles  = 60;
  localparam int unsigned PhaseItems   = 333;
  localparam int unsigned NumPhases    = 4;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  logic [OffW-1:0] day_offset = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic [YearW-1:0]  year;
  logic [MonthW-1:0] month;
  logic [DayW-1:0]   day_of_month;
  logic              valid_res;

  int unsigned mismatch_count;
  int unsigned dates_owed;

  // idle percentages per phase, and the hold-off request to the receiver
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  bit          rx_hold_req = 1'b0;
  int unsigned quiet_cycles = 0;

  // idling mix per phase: none, sender heavy, receiver heavy, both light
  int unsigned tx_pct_of[NumPhases] = '{0, 82, 0, 8};
  int unsigned rx_pct_of[NumPhases] = '{0, 0, 82, 8};

  // Directed offsets: field extremes, range edges, century leap rules
  // (1900 not leap, 2000 leap) and the epoch itself.
  int directed_offsets[] = '{
    -4194304, -711860, -711859, -711858,
    -133758, -133757, -133747, -133737, -133736,
    -18205, -18204, -18203,
    -1, 0, 1,
    18321, 18322, 2940200, 2940201, 2940202,
    4194303, -2, 4194302
  };

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  day_count_to_calendar_date dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .day_offset_i   (day_offset),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .year_o         (year),
    .month_o        (month),
    .day_of_month_o (day_of_month),
    .valid_res_o    (valid_res)
  );

  dcc_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .day_offset_i     (day_offset),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .year_i           (year),
    .month_i          (month),
    .day_of_month_i   (day_of_month),
    .valid_res_i      (valid_res),
    .mismatch_count_o (mismatch_count),
    .dates_owed_o     (dates_owed)
  );

  // Watchdog: any transaction on either channel restarts the count.
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= StallLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random stalls, plus one long hold-off counted here on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (RxHoldCycles) @(posedge clk_i);
      end
      out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // One input transaction; valid stays high straight into the next item
  // when no idle cycle is drawn.
  task automatic send_offset(input logic [OffW-1:0] off);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    day_offset <= off;
    do begin
      @(posedge clk_i);
    end while (!in_ready);
  endtask

  initial begin
    int          off;
    int unsigned pick;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_offsets[k]) begin
      send_offset(directed_offsets[k][OffW-1:0]);
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      tx_idle_pct  = tx_pct_of[ph];
      rx_stall_pct = rx_pct_of[ph];
      // receiver goes quiet while the sender keeps offering items
      if (ph == 0) begin
        rx_hold_req = 1'b1;
      end
      for (int n = 0; n < PhaseItems; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          // anywhere in years 1 to 9999
          off = int'($urandom_range(0, 3652060)) - 711859;
        end else if (pick < 68) begin
          // about a year after the changeover month, in the autumn of 1583
          off = int'($urandom_range(0, 80)) - 133787;
        end else if (pick < 78) begin
          // year and leap-day edges near the epoch
          off = int'($urandom_range(0, 1600)) - 800;
        end else if (pick < 84) begin
          // close to either end of the valid range
          off = $urandom_range(0, 1) ? int'($urandom_range(0, 40)) - 711879
                                     : int'($urandom_range(0, 40)) + 2940181;
        end else begin
          // whole field, mostly out of range
          off = int'($urandom());
        end
        send_offset(off[OffW-1:0]);
      end
      // sender pause until every owed date is back; one edge first so the
      // last accepted transaction is already counted
      in_valid <= 1'b0;
      @(posedge clk_i);
      while (dates_owed != 0) @(posedge clk_i);
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && dates_owed == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
